// File: rtl/lcpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcpd_pkg;

  // default width of the announced payload size
  localparam int SIZE_BITS_DEF = 24;

  // characters the parser looks for
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // keyword indexes into the match vector
  localparam int KW_INFO_IDX = 0;
  localparam int KW_MSG_IDX  = 1;
  localparam int KW_PONG_IDX = 2;
  localparam int KW_ERR_IDX  = 3;

  // keyword text, first character in the top byte
  localparam logic [3:0][31:0] KW_TEXT = {"-ERR", "PONG", {"MSG", 8'h00}, "INFO"};
  localparam logic [3:0][2:0]  KW_LEN  = {3'd4, 3'd4, 3'd3, 3'd4};

  // token index that carries the payload size in a message line
  localparam logic [2:0] SIZE_TOKEN = 3'd3;

  typedef enum logic [1:0] {
    MODE_LINE,
    MODE_PAYLOAD,
    MODE_DROP1,
    MODE_DROP2
  } mode_t;

  typedef enum logic [2:0] {
    EV_HANDSHAKE = 3'd0,
    EV_HEADER    = 3'd1,
    EV_PAYLOAD   = 3'd2,
    EV_PONG      = 3'd3,
    EV_ERROR     = 3'd4
  } event_t;

  // one input item as it sits in the input register
  typedef struct packed {
    logic       restart;
    logic [7:0] rx_byte;
  } item_t;

  // character i of keyword k
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [1:0] i);
    return KW_TEXT[k][{~i, 3'b000} +: 8];
  endfunction

endpackage : lcpd_pkg

`default_nettype wire

// File: rtl/lcpd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module lcpd_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire lcpd_pkg::item_t in_item,
  output logic                stg_valid,
  input  wire logic           stg_ready,
  output lcpd_pkg::item_t     stg_item
);
  import lcpd_pkg::*;

  logic  valid_r;
  item_t item_r;

  // register refills when empty or when its content moves on
  assign in_ready  = !valid_r || stg_ready;
  assign stg_valid = valid_r;
  assign stg_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule : lcpd_in_stage

`default_nettype wire

// File: rtl/lcpd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module lcpd_parser #(
  parameter int SIZE_BITS = lcpd_pkg::SIZE_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            stg_valid,
  output logic                 stg_ready,
  input  wire lcpd_pkg::item_t stg_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output lcpd_pkg::event_t     out_event_kind,
  output logic [7:0]           out_payload_byte,
  output logic [SIZE_BITS-1:0] out_payload_size,
  output logic                 out_last_byte
);
  import lcpd_pkg::*;

  // per-line parse state
  typedef struct packed {
    logic                 pend_cr;
    logic [2:0]           tok_cnt;
    logic [2:0]           tok_pos;
    logic [3:0]           kw;
    logic [SIZE_BITS-1:0] acc;
    logic                 ok;
  } line_t;

  localparam line_t LINE_CLEAR = '{pend_cr: 1'b0, tok_cnt: 3'd0, tok_pos: 3'd0,
                                   kw: 4'hF, acc: '0, ok: 1'b0};

  // drop keywords whose length differs from the finished first token
  function automatic logic [3:0] kw_finish(input logic [3:0] kw, input logic [2:0] pos);
    logic [3:0] r;
    r = kw;
    for (int k = 0; k < 4; k++) begin
      if (pos != KW_LEN[k]) r[k] = 1'b0;
    end
    return r;
  endfunction

  // drop keywords that do not have byte b at position pos
  function automatic logic [3:0] kw_step(input logic [3:0] kw, input logic [2:0] pos,
                                         input logic [7:0] b);
    logic [3:0] r;
    r = kw;
    for (int k = 0; k < 4; k++) begin
      if (pos >= KW_LEN[k] || kw_char(k[1:0], pos[1:0]) != b) r[k] = 1'b0;
    end
    return r;
  endfunction

  // one ordinary line byte applied to the line state
  function automatic line_t line_byte(input line_t s, input logic [7:0] b);
    line_t                r;
    logic [SIZE_BITS-1:0] base_acc;
    logic                 base_ok;
    logic                 digit;
    logic [SIZE_BITS+3:0] wide;
    logic [SIZE_BITS+3:0] prod;
    r        = s;
    base_acc = (s.tok_pos == 3'd0) ? '0 : s.acc;
    base_ok  = (s.tok_pos == 3'd0) ? 1'b1 : s.ok;
    digit    = (b >= CH_ZERO) && (b <= CH_NINE);
    wide     = {4'b0000, base_acc};
    prod     = (wide << 3) + (wide << 1) + {{SIZE_BITS{1'b0}}, b[3:0]};
    if (b == CH_SP) begin
      if (s.tok_cnt == 3'd0) r.kw = kw_finish(s.kw, s.tok_pos);
      if (s.tok_cnt != 3'd7) r.tok_cnt = s.tok_cnt + 3'd1;
      r.tok_pos = 3'd0;
      if (r.tok_cnt == SIZE_TOKEN) begin
        r.acc = '0;
        r.ok  = 1'b0;
      end
    end else begin
      if (s.tok_cnt == 3'd0) begin
        r.kw = kw_step(s.kw, s.tok_pos, b);
      end else if (s.tok_cnt == SIZE_TOKEN) begin
        if (digit) begin
          r.acc = base_acc;
          r.ok  = base_ok;
          if (base_ok) begin
            if (prod[SIZE_BITS+3:SIZE_BITS] != 4'd0) r.ok = 1'b0;
            else r.acc = prod[SIZE_BITS-1:0];
          end
        end else begin
          r.ok = 1'b0;
        end
      end
      if (s.tok_pos != 3'd7) r.tok_pos = s.tok_pos + 3'd1;
    end
    return r;
  endfunction

  mode_t                mode_r,  mode_nxt;
  line_t                line_r,  line_nxt;
  logic [SIZE_BITS-1:0] left_r,  left_nxt;
  logic                 hs_r,    hs_nxt;

  logic                 out_valid_r;
  event_t               kind_r;
  logic [7:0]           byte_r;
  logic [SIZE_BITS-1:0] size_r;
  logic                 last_r;

  logic                 go;
  logic [7:0]           b;
  logic                 eol;
  line_t                line_cr;
  line_t                line_step;
  logic [3:0]           kw_end;
  logic                 hit_hs, msg_line, hit_msg, hit_pong, hit_err;
  logic [SIZE_BITS-1:0] left_dec;

  logic                 res_v;
  event_t               res_kind;
  logic [7:0]           res_byte;
  logic [SIZE_BITS-1:0] res_size;
  logic                 res_last;

  // an item is worked on when the result register can take its result
  assign stg_ready = !out_valid_r || out_ready;
  assign go        = stg_valid && stg_ready;
  assign b         = stg_item.rx_byte;
  assign eol       = line_r.pend_cr && (b == CH_LF);
  assign left_dec  = (left_r != '0) ? left_r - 1'b1 : left_r;

  // line byte path: a held CR that was not followed by LF counts as data first
  always_comb begin
    line_cr = line_r;
    if (line_r.pend_cr) begin
      line_cr         = line_byte(line_r, CH_CR);
      line_cr.pend_cr = 1'b0;
    end
    if (b == CH_CR) begin
      line_step         = line_cr;
      line_step.pend_cr = 1'b1;
    end else begin
      line_step = line_byte(line_cr, b);
    end
  end

  // line classification at CR LF, in priority order
  always_comb begin
    kw_end   = (line_r.tok_cnt == 3'd0) ? kw_finish(line_r.kw, line_r.tok_pos) : line_r.kw;
    hit_hs   = kw_end[KW_INFO_IDX] && !hs_r;
    msg_line = !hit_hs && (line_r.tok_cnt == SIZE_TOKEN) && kw_end[KW_MSG_IDX];
    hit_msg  = msg_line && line_r.ok;
    hit_pong = !hit_hs && !msg_line && kw_end[KW_PONG_IDX];
    hit_err  = !hit_hs && !msg_line && !kw_end[KW_PONG_IDX] && kw_end[KW_ERR_IDX];
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    line_nxt = line_r;
    left_nxt = left_r;
    hs_nxt   = hs_r;
    if (go) begin
      if (stg_item.restart) begin
        hs_nxt = 1'b0;
      end else begin
        unique case (mode_r)
          MODE_PAYLOAD: begin
            left_nxt = left_dec;
            if (left_dec == '0) mode_nxt = MODE_DROP1;
          end
          MODE_DROP1: mode_nxt = MODE_DROP2;
          MODE_DROP2: mode_nxt = MODE_LINE;
          MODE_LINE: begin
            if (eol) begin
              line_nxt = LINE_CLEAR;
              if (hit_hs) hs_nxt = 1'b1;
              if (hit_msg) begin
                left_nxt = line_r.acc;
                mode_nxt = (line_r.acc != '0) ? MODE_PAYLOAD : MODE_DROP1;
              end
            end else begin
              line_nxt = line_step;
            end
          end
          default: mode_nxt = MODE_LINE;
        endcase
      end
    end
  end

  // result of the item
  always_comb begin
    res_v    = 1'b0;
    res_kind = EV_HANDSHAKE;
    res_byte = 8'd0;
    res_size = '0;
    res_last = 1'b0;
    if (!stg_item.restart) begin
      unique case (mode_r)
        MODE_PAYLOAD: begin
          res_v    = 1'b1;
          res_kind = EV_PAYLOAD;
          res_byte = b;
          res_last = (left_r == SIZE_BITS'(1));
        end
        MODE_LINE: begin
          if (eol) begin
            priority if (hit_hs) begin
              res_v = 1'b1;
            end else if (hit_msg) begin
              res_v    = 1'b1;
              res_kind = EV_HEADER;
              res_size = line_r.acc;
            end else if (hit_pong) begin
              res_v    = 1'b1;
              res_kind = EV_PONG;
            end else if (hit_err) begin
              res_v    = 1'b1;
              res_kind = EV_ERROR;
            end else begin
              res_v = 1'b0;
            end
          end
        end
        MODE_DROP1, MODE_DROP2: res_v = 1'b0;
        default: res_v = 1'b0;
      endcase
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LINE;
      line_r <= LINE_CLEAR;
      left_r <= '0;
      hs_r   <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      left_r <= left_nxt;
      hs_r   <= hs_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_ready) begin
      out_valid_r <= go && res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_v) begin
      kind_r <= res_kind;
      byte_r <= res_byte;
      size_r <= res_size;
      last_r <= res_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = kind_r;
  assign out_payload_byte = byte_r;
  assign out_payload_size = size_r;
  assign out_last_byte    = last_r;

endmodule : lcpd_parser

`default_nettype wire

// File: rtl/line_command_payload_deframer.sv
// Path: an accepted byte waits in the input register; the parser takes it from there and, when it
//   yields a result, loads the result register once that register can take it.
// Throughput: one byte per cycle while out_ready is high; the parse state updates in one pass
//   per byte and the input and result registers let a new transfer in while a result waits.
// Reset: synchronous, active low; clears parse mode, line state, byte count,
//   handshake mark and both valid flags. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module line_command_payload_deframer #(
  parameter int SIZE_BITS = lcpd_pkg::SIZE_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_rx_byte,
  input  wire logic            in_restart,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [2:0]           out_event_kind,
  output logic [7:0]           out_payload_byte,
  output logic [SIZE_BITS-1:0] out_payload_size,
  output logic                 out_last_byte
);
  import lcpd_pkg::*;

  item_t  in_item;
  item_t  stg_item;
  logic   stg_valid;
  logic   stg_ready;
  event_t kind;

  assign in_item.rx_byte = in_rx_byte;
  assign in_item.restart = in_restart;

  // input register
  lcpd_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .stg_valid (stg_valid),
    .stg_ready (stg_ready),
    .stg_item  (stg_item)
  );

  // framing, classification and result register
  lcpd_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .stg_valid        (stg_valid),
    .stg_ready        (stg_ready),
    .stg_item         (stg_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (kind),
    .out_payload_byte (out_payload_byte),
    .out_payload_size (out_payload_size),
    .out_last_byte    (out_last_byte)
  );

  assign out_event_kind = kind;

endmodule : line_command_payload_deframer

`default_nettype wire
